### rtl/zrle_pkg.sv
// Shared constants, types and helper functions for the zero-run/literal encoder.
`default_nettype none
package zrle_pkg;

  // Literal runs are split at this many bytes.
  localparam int LITERAL_LIMIT = 32;
  localparam int CNT_W         = $clog2(LITERAL_LIMIT + 1);
  // Two banks of literal storage, each addressed by a literal count.
  localparam int MEM_AW        = CNT_W + 1;
  localparam int MEM_DEPTH     = 1 << MEM_AW;

  localparam logic [CNT_W-1:0] LIT_LIMIT_C     = CNT_W'(LITERAL_LIMIT);
  localparam logic [7:0]       TAG_ZERO_RUN    = 8'h00;
  localparam logic [7:0]       TAG_LITERAL_RUN = 8'h01;
  localparam logic [15:0]      ZERO_RUN_MAX    = 16'hFFFF;

  // Command queue between the front and back sections.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // One command describes every output byte caused by one request.
  typedef struct packed {
    logic             hdr;        // emit the stream length header first
    logic             lit_first;  // literal run comes before the zero run
    logic [15:0]      zrun;       // zero run count, zero means none
    logic [CNT_W-1:0] lcnt;       // literal run count, zero means none
    logic             bank;       // literal bank holding the run
    logic             last;       // request carried the last byte
  } cmd_t;

  // Literal store write from the front section.
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } lit_wr_t;

  // Literal bank release from the back section.
  typedef struct packed {
    logic valid;
    logic bank;
  } lit_rel_t;

  // Front section status.
  typedef struct packed {
    logic [1:0] busy;
    logic       bank;
  } front_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_LO,
    ST_HDR_HI,
    ST_ZTAG,
    ST_ZLO,
    ST_ZHI,
    ST_LTAG,
    ST_LLO,
    ST_LHI,
    ST_LDAT
  } bk_state_t;

  // First run record of a command after any header.
  function automatic bk_state_t first_seg(cmd_t c);
    bk_state_t s;
    if (c.lit_first) begin
      s = (c.lcnt != '0) ? ST_LTAG : ((c.zrun != '0) ? ST_ZTAG : ST_IDLE);
    end else begin
      s = (c.zrun != '0) ? ST_ZTAG : ((c.lcnt != '0) ? ST_LTAG : ST_IDLE);
    end
    return s;
  endfunction

  // Next record once the zero run record is done.
  function automatic bk_state_t after_zero(cmd_t c);
    bk_state_t s;
    if (!c.lit_first && (c.lcnt != '0)) begin
      s = ST_LTAG;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  // Next record once the literal run record is done.
  function automatic bk_state_t after_lit(cmd_t c);
    bk_state_t s;
    if (c.lit_first && (c.zrun != '0)) begin
      s = ST_ZTAG;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/zrle_if.sv
// Valid/ready channel interfaces for the input bytes and the encoded bytes.
`default_nettype none
interface zrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface zrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       item_end;
  logic       stream_end;

  modport source (output valid, output out_byte, output item_end, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input item_end, input stream_end,
                  output ready);
endinterface
`default_nettype wire

### rtl/zrle_fifo.sv
// Small command queue between the front and back sections.
`default_nettype none
module zrle_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zrle_pkg::cmd_t push_cmd,
  input  logic          pop,
  output zrle_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import zrle_pkg::*;

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign full  = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

### rtl/zrle_front.sv
// Front section: accepts input bytes, tracks runs and writes literals.
`default_nettype none
module zrle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  zrle_in_if.sink              in_ch,
  input  logic                 fifo_full,
  output logic                 push,
  output zrle_pkg::cmd_t       push_cmd,
  output zrle_pkg::lit_wr_t    lit_wr,
  input  zrle_pkg::lit_rel_t   lit_rel,
  output zrle_pkg::front_stat_t stat
);
  import zrle_pkg::*;

  logic             header_done_r, header_done_nxt;
  logic [15:0]      zero_count_r, zero_count_nxt;
  logic [CNT_W-1:0] lit_count_r, lit_count_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;

  logic             accept;
  logic [15:0]      zc_inc;
  logic [CNT_W-1:0] lc_inc;

  // A new literal bank can only be opened once the back section released it.
  assign in_ch.ready = !fifo_full && !(busy_r[bank_r] && (lit_count_r == '0));
  assign accept      = in_ch.valid && in_ch.ready;
  assign zc_inc      = zero_count_r + 16'd1;
  assign lc_inc      = lit_count_r + CNT_W'(1);

  assign stat.busy = busy_r;
  assign stat.bank = bank_r;

  // Classify the request and build its command.
  always_comb begin
    header_done_nxt    = header_done_r;
    zero_count_nxt     = zero_count_r;
    lit_count_nxt      = lit_count_r;
    bank_nxt           = bank_r;
    push_cmd.hdr       = !header_done_r;
    push_cmd.lit_first = 1'b0;
    push_cmd.zrun      = '0;
    push_cmd.lcnt      = '0;
    push_cmd.bank      = bank_r;
    push_cmd.last      = in_ch.last_byte;
    lit_wr.en          = 1'b0;
    lit_wr.addr        = {bank_r, lit_count_r};
    lit_wr.data        = in_ch.data_byte;
    if (accept) begin
      header_done_nxt = !in_ch.last_byte;
      if (in_ch.data_byte == 8'h00) begin
        // A zero byte flushes pending literals, then counts.
        push_cmd.lit_first = 1'b1;
        push_cmd.lcnt      = lit_count_r;
        lit_count_nxt      = '0;
        if (lit_count_r != '0) begin
          bank_nxt = !bank_r;
        end
        if (zc_inc == ZERO_RUN_MAX || in_ch.last_byte) begin
          push_cmd.zrun  = zc_inc;
          zero_count_nxt = '0;
        end else begin
          zero_count_nxt = zc_inc;
        end
      end else begin
        // A nonzero byte flushes a pending zero run, then is stored.
        push_cmd.zrun  = zero_count_r;
        zero_count_nxt = '0;
        lit_wr.en      = 1'b1;
        if (lc_inc == LIT_LIMIT_C || in_ch.last_byte) begin
          push_cmd.lcnt = lc_inc;
          lit_count_nxt = '0;
          bank_nxt      = !bank_r;
        end else begin
          lit_count_nxt = lc_inc;
        end
      end
    end
  end

  assign push = accept && (push_cmd.hdr || (push_cmd.zrun != '0) || (push_cmd.lcnt != '0));

  // Bank ownership: set when a literal run is queued, cleared when sent.
  always_comb begin
    busy_nxt = busy_r;
    if (lit_rel.valid) begin
      busy_nxt[lit_rel.bank] = 1'b0;
    end
    if (push && (push_cmd.lcnt != '0)) begin
      busy_nxt[push_cmd.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_done_r <= 1'b0;
      zero_count_r  <= '0;
      lit_count_r   <= '0;
      bank_r        <= 1'b0;
      busy_r        <= '0;
    end else begin
      header_done_r <= header_done_nxt;
      zero_count_r  <= zero_count_nxt;
      lit_count_r   <= lit_count_nxt;
      bank_r        <= bank_nxt;
      busy_r        <= busy_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/zrle_back.sv
// Back section: literal store and byte sequencer that writes the encoded stream.
`default_nettype none
module zrle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fifo_empty,
  input  zrle_pkg::cmd_t     head,
  output logic               pop,
  input  zrle_pkg::lit_wr_t  lit_wr,
  output zrle_pkg::lit_rel_t lit_rel,
  input  logic [15:0]        stream_length,
  zrle_out_if.source         out_ch
);
  import zrle_pkg::*;

  bk_state_t        state_r, state_nxt;
  cmd_t             cmd_r;
  logic [CNT_W-1:0] lit_idx_r, lit_idx_nxt;
  logic [CNT_W-1:0] lit_idx_inc;
  logic             lit_final;
  logic             adv;
  logic [15:0]      lcnt_word;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data_r;
  logic              rd_en;
  logic [MEM_AW-1:0] rd_addr;

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       item_end_r;
  logic       stream_end_r;

  assign adv         = (state_r != ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign lit_idx_inc = lit_idx_r + CNT_W'(1);
  assign lit_final   = (lit_idx_inc == cmd_r.lcnt);
  assign lcnt_word   = 16'(cmd_r.lcnt);

  // Next state of the byte sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          state_nxt = head.hdr ? ST_HDR_LO : first_seg(head);
        end
      end
      ST_HDR_LO: if (adv) state_nxt = ST_HDR_HI;
      ST_HDR_HI: if (adv) state_nxt = first_seg(cmd_r);
      ST_ZTAG:   if (adv) state_nxt = ST_ZLO;
      ST_ZLO:    if (adv) state_nxt = ST_ZHI;
      ST_ZHI:    if (adv) state_nxt = after_zero(cmd_r);
      ST_LTAG:   if (adv) state_nxt = ST_LLO;
      ST_LLO:    if (adv) state_nxt = ST_LHI;
      ST_LHI:    if (adv) state_nxt = ST_LDAT;
      ST_LDAT: begin
        if (adv && lit_final) begin
          state_nxt = after_lit(cmd_r);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Byte selection, literal prefetch and bank release.
  always_comb begin
    pop           = 1'b0;
    out_byte_nxt  = 8'h00;
    rd_en         = 1'b0;
    rd_addr       = {cmd_r.bank, lit_idx_inc};
    lit_idx_nxt   = lit_idx_r;
    lit_rel.valid = 1'b0;
    lit_rel.bank  = cmd_r.bank;
    case (state_r)
      ST_IDLE:   pop = !fifo_empty;
      ST_HDR_LO: out_byte_nxt = stream_length[7:0];
      ST_HDR_HI: out_byte_nxt = stream_length[15:8];
      ST_ZTAG:   out_byte_nxt = TAG_ZERO_RUN;
      ST_ZLO:    out_byte_nxt = cmd_r.zrun[7:0];
      ST_ZHI:    out_byte_nxt = cmd_r.zrun[15:8];
      ST_LTAG:   out_byte_nxt = TAG_LITERAL_RUN;
      ST_LLO:    out_byte_nxt = lcnt_word[7:0];
      ST_LHI: begin
        // Fetch the first literal while the count goes out.
        out_byte_nxt = lcnt_word[15:8];
        rd_en        = adv;
        rd_addr      = {cmd_r.bank, {CNT_W{1'b0}}};
        if (adv) begin
          lit_idx_nxt = '0;
        end
      end
      ST_LDAT: begin
        out_byte_nxt = rd_data_r;
        rd_en        = adv && !lit_final;
        if (adv) begin
          lit_idx_nxt   = lit_idx_inc;
          lit_rel.valid = lit_final;
        end
      end
      default: out_byte_nxt = 8'h00;
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.item_end   = item_end_r;
  assign out_ch.stream_end = stream_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    lit_idx_r <= lit_idx_nxt;
    if (pop) begin
      cmd_r <= head;
    end
    if (adv) begin
      out_byte_r   <= out_byte_nxt;
      item_end_r   <= (state_nxt == ST_IDLE);
      stream_end_r <= (state_nxt == ST_IDLE) && cmd_r.last;
    end
  end

  // Literal store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (lit_wr.en) begin
      mem[lit_wr.addr] <= lit_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

### rtl/zero_run_literal_encoder.sv
// A request's first byte passes the queue, the sequencer state and the output register.
// Throughput: one encoded byte per cycle while out_ch.ready holds, with an idle state per
// queued command; alternating zero and nonzero bytes share the single output byte port.
// Input bytes are taken one per cycle while the 4-entry queue and a literal bank have room.
// Reset (synchronous, rst_n low) clears run counters, queue and sequencer and sets
// stream_length to 1; the literal store is not cleared.
`default_nettype none
module zero_run_literal_encoder (
  input  logic        clk,
  input  logic        rst_n,
  zrle_in_if.sink     in_ch,
  zrle_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import zrle_pkg::*;

  logic [15:0] stream_length_r;
  logic        push;
  logic        pop;
  logic        fifo_full;
  logic        fifo_empty;
  cmd_t        push_cmd;
  cmd_t        head;
  lit_wr_t     lit_wr;
  lit_rel_t    lit_rel;
  front_stat_t stat;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_length_r <= 16'd1;
    end else if (cfg_we) begin
      stream_length_r <= cfg_wdata;
    end
  end

  zrle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .lit_wr    (lit_wr),
    .lit_rel   (lit_rel),
    .stat      (stat)
  );

  zrle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  zrle_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_empty    (fifo_empty),
    .head          (head),
    .pop           (pop),
    .lit_wr        (lit_wr),
    .lit_rel       (lit_rel),
    .stream_length (stream_length_r),
    .out_ch        (out_ch)
  );

  // The queue is never written while full.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("command queued while the queue is full");

  // Literals are never written into a bank still owned by the back section.
  a_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
    lit_wr.en |-> !stat.busy[lit_wr.addr[MEM_AW-1]])
    else $error("literal written into a busy bank");

  // A released bank must have been owned.
  a_rel_owned: assert property (@(posedge clk) disable iff (!rst_n)
    lit_rel.valid |-> stat.busy[lit_rel.bank])
    else $error("literal bank released while not in use");

  // The end of the stream is always the end of a request's bytes.
  a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stream_end |-> out_ch.item_end)
    else $error("stream end without item end");
endmodule
`default_nettype wire
